### design/apdbs_pkg.sv
// shared constants and name canonicalization for the access-point list filter
`default_nettype none

package apdbs_pkg;

	localparam int LIST_DEPTH_DEF = 16;
	localparam int NAME_BYTES     = 32;
	localparam int NAME_BITS      = NAME_BYTES * 8;
	localparam int LEVEL_W        = 8;
	localparam int ORIGIN_W       = 4;
	localparam int ENTRY_W        = LEVEL_W + ORIGIN_W;
	localparam int TOTAL_W        = 5;

	// clear every byte after the first zero byte
	function automatic logic [NAME_BITS-1:0] canon_name(input logic [NAME_BITS-1:0] raw);
		logic [NAME_BYTES-1:0] zero_b;
		logic [NAME_BYTES-1:0] below;
		logic [NAME_BITS-1:0]  kept;
		for (int b = 0; b < NAME_BYTES; b++) begin
			zero_b[b] = (raw[8*b +: 8] == 8'h00);
		end
		for (int b = 0; b < NAME_BYTES; b++) begin
			below = zero_b & ((NAME_BYTES'(1) << b) - NAME_BYTES'(1));
			kept[8*b +: 8] = (below == '0) ? raw[8*b +: 8] : 8'h00;
		end
		return kept;
	endfunction

endpackage

`default_nettype wire

### design/apdbs_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module apdbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### design/ap_dedupe_best_signal_sort.sv
// access-point list filter: dedupe by name keeping the strongest, then rank by strength
//
//   channel   handshake              payload
//   -------   ---------------------  -------------------------------------------------
//   record    start & !busy          name_word0..3, signal_level, record_index,
//                                    last_record
//   result    strobe (one cycle)     chosen_index, strength, final_entry,
//                                    distinct_total, overflowed
//
// per record: one name compare per cycle against the name ram, reads issued one
//   ahead, then an update on a hit or an append on a miss, and a return to idle
// the last record adds the exchange sort on the entry ram, then streams the n
//   results out
// reset clears the sequencer, entry count and drop flag; ram contents are not cleared
// busy is high for the whole of a record's work; results are one-cycle strobes that
//   the receiver cannot stall
`default_nettype none

module ap_dedupe_best_signal_sort
	import apdbs_pkg::*;
#(
	parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic [63:0]                name_word0,
	input  wire logic [63:0]                name_word1,
	input  wire logic [63:0]                name_word2,
	input  wire logic [63:0]                name_word3,
	input  wire logic signed [LEVEL_W-1:0]  signal_level,
	input  wire logic [ORIGIN_W-1:0]        record_index,
	input  wire logic                       last_record,
	output logic                            strobe,
	output logic [ORIGIN_W-1:0]             chosen_index,
	output logic signed [LEVEL_W-1:0]       strength,
	output logic                            final_entry,
	output logic [TOTAL_W-1:0]              distinct_total,
	output logic                            overflowed
);

	localparam int AW = $clog2(LIST_DEPTH);
	localparam int CW = $clog2(LIST_DEPTH + 1);

	// sequencer states
	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_SCAN     = 3'd1;
	localparam logic [2:0] S_APPEND   = 3'd2;
	localparam logic [2:0] S_SORT_LD  = 3'd3;
	localparam logic [2:0] S_SORT_CUR = 3'd4;
	localparam logic [2:0] S_SORT_J   = 3'd5;
	localparam logic [2:0] S_EMIT     = 3'd6;

	logic [2:0]               state_q;
	logic [CW-1:0]            ptr_q;      // issue pointer shared by scan, inner sort and emit
	logic [CW-1:0]            i_q;        // outer sort index
	logic                     pend_q;     // a read issued last cycle, data now on the ram port
	logic [AW-1:0]            pidx_q;     // address of that read
	logic [CW-1:0]            count_q;
	logic                     drop_q;

	// captured record
	logic [NAME_BITS-1:0]     name_q;
	logic signed [LEVEL_W-1:0] level_q;
	logic [ORIGIN_W-1:0]      origin_q;
	logic                     last_q;

	// entry held in hand during one outer sort pass
	logic [ENTRY_W-1:0]       cur_q;

	// result registers
	logic                     strobe_q;
	logic [ORIGIN_W-1:0]      chosen_q;
	logic [LEVEL_W-1:0]       strength_q;
	logic                     final_q;
	logic [TOTAL_W-1:0]       total_q;
	logic                     ovf_q;

	// ram ports
	logic                     name_we;
	logic [NAME_BITS-1:0]     name_rdata;
	logic                     ent_we;
	logic [AW-1:0]            ent_waddr;
	logic [ENTRY_W-1:0]       ent_wdata;
	logic [AW-1:0]            ent_raddr;
	logic [ENTRY_W-1:0]       ent_rdata;

	logic                     issue;
	logic                     has_room;
	logic                     name_hit;
	logic signed [LEVEL_W-1:0] rd_level;
	logic signed [LEVEL_W-1:0] cur_level;

	assign issue     = (ptr_q < count_q);
	assign has_room  = (count_q < CW'(LIST_DEPTH));
	assign name_hit  = pend_q && (name_rdata == name_q);
	assign rd_level  = $signed(ent_rdata[ENTRY_W-1 -: LEVEL_W]);
	assign cur_level = $signed(cur_q[ENTRY_W-1 -: LEVEL_W]);

	assign name_we   = (state_q == S_APPEND) && has_room;
	assign ent_raddr = (state_q == S_SORT_LD) ? i_q[AW-1:0] : ptr_q[AW-1:0];

	// one write port on the entry ram, shared by update, append, sort swaps and the settle of each sort pass
	always_comb begin
		ent_we    = 1'b0;
		ent_waddr = pidx_q;
		ent_wdata = {level_q, origin_q};
		case (state_q)
			S_SCAN: begin
				// equal name: replace only when strictly stronger
				if (name_hit && (level_q > rd_level)) begin
					ent_we = 1'b1;
				end
			end
			S_APPEND: begin
				ent_we    = has_room;
				ent_waddr = count_q[AW-1:0];
			end
			S_SORT_J: begin
				if (pend_q && (cur_level < rd_level)) begin
					// swap: held entry goes to slot j, slot j's entry is taken in hand
					ent_we    = 1'b1;
					ent_wdata = cur_q;
				end else if (!issue && !pend_q) begin
					// inner pass done: the held entry settles at slot i
					ent_we    = 1'b1;
					ent_waddr = i_q[AW-1:0];
					ent_wdata = cur_q;
				end
			end
			default: begin
				ent_we = 1'b0;
			end
		endcase
	end

	apdbs_ram #(
		.WIDTH (NAME_BITS),
		.DEPTH (LIST_DEPTH)
	) u_name_ram (
		.clk   (clk),
		.we    (name_we),
		.waddr (count_q[AW-1:0]),
		.wdata (name_q),
		.raddr (ptr_q[AW-1:0]),
		.rdata (name_rdata)
	);

	apdbs_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (LIST_DEPTH)
	) u_entry_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (ent_wdata),
		.raddr (ent_raddr),
		.rdata (ent_rdata)
	);

	// record capture, name canonicalized on the way in
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && start) begin
			name_q   <= canon_name({name_word3, name_word2, name_word1, name_word0});
			level_q  <= signal_level;
			origin_q <= record_index;
			last_q   <= last_record;
		end
	end

	// held entry for the sort
	always_ff @(posedge clk) begin
		if (state_q == S_SORT_CUR) begin
			cur_q <= ent_rdata;
		end else if ((state_q == S_SORT_J) && pend_q && (cur_level < rd_level)) begin
			cur_q <= ent_rdata;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if ((state_q == S_EMIT) && pend_q) begin
			chosen_q   <= ent_rdata[ORIGIN_W-1:0];
			strength_q <= ent_rdata[ENTRY_W-1 -: LEVEL_W];
			final_q    <= ((CW'(pidx_q) + CW'(1)) == count_q);
			total_q    <= TOTAL_W'(count_q);
			ovf_q      <= drop_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ptr_q    <= '0;
			i_q      <= '0;
			pend_q   <= 1'b0;
			pidx_q   <= '0;
			count_q  <= '0;
			drop_q   <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (state_q == S_EMIT) && pend_q;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						ptr_q   <= '0;
						pend_q  <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					// one name compare per cycle, reads issued one ahead
					if (name_hit) begin
						pend_q  <= 1'b0;
						i_q     <= '0;
						state_q <= last_q ? S_SORT_LD : S_IDLE;
					end else if (!issue && !pend_q) begin
						state_q <= S_APPEND;
					end else begin
						pend_q <= issue;
						pidx_q <= ptr_q[AW-1:0];
						if (issue) begin
							ptr_q <= ptr_q + CW'(1);
						end
					end
				end
				S_APPEND: begin
					if (has_room) begin
						count_q <= count_q + CW'(1);
					end else begin
						drop_q <= 1'b1;
					end
					i_q     <= '0;
					state_q <= last_q ? S_SORT_LD : S_IDLE;
				end
				S_SORT_LD: begin
					if (i_q < count_q) begin
						state_q <= S_SORT_CUR;
					end else begin
						ptr_q   <= '0;
						pend_q  <= 1'b0;
						state_q <= S_EMIT;
					end
				end
				S_SORT_CUR: begin
					ptr_q   <= i_q + CW'(1);
					pend_q  <= 1'b0;
					state_q <= S_SORT_J;
				end
				S_SORT_J: begin
					if (!issue && !pend_q) begin
						i_q     <= i_q + CW'(1);
						state_q <= S_SORT_LD;
					end else begin
						pend_q <= issue;
						pidx_q <= ptr_q[AW-1:0];
						if (issue) begin
							ptr_q <= ptr_q + CW'(1);
						end
					end
				end
				S_EMIT: begin
					if (!issue && !pend_q) begin
						// list delivered, clear it and return to idle for a fresh scan
						count_q <= '0;
						drop_q  <= 1'b0;
						state_q <= S_IDLE;
					end else begin
						pend_q <= issue;
						pidx_q <= ptr_q[AW-1:0];
						if (issue) begin
							ptr_q <= ptr_q + CW'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy           = (state_q != S_IDLE);
	assign strobe         = strobe_q;
	assign chosen_index   = chosen_q;
	assign strength       = $signed(strength_q);
	assign final_entry    = final_q;
	assign distinct_total = total_q;
	assign overflowed     = ovf_q;

endmodule

`default_nettype wire
